// ===== rtl/cwft_pkg.sv =====
// Package for the cache way feature tracker: action codes, kind constants,
// the command word carried from front to back, and the back-end state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cwft_pkg;

	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_FILL   = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [2:0] KIND_MAX  = 3'd4;
	localparam logic [2:0] KIND_NONE = 3'd5;

	// most results one read returns, and the width of reported counters
	localparam int RESULTS_MAX = 8;
	localparam int RANK_W      = 3;
	localparam int OUT_CNT_W   = 16;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  set_index;
		logic [2:0]  way_index;
		logic        hit;
		logic [2:0]  kind;
		logic [23:0] recency_packed;
	} cmd_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_WAIT,
		B_EMIT
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/cwft_if.sv =====
// Request and result channel interfaces of the cache way feature tracker.
// Independent of the package; valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface cwft_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [5:0]  set_index;
	logic [2:0]  way_index;
	logic        hit;
	logic [2:0]  access_kind;
	logic [23:0] recency_packed;

	modport source (output valid, action, set_index, way_index, hit, access_kind,
		recency_packed, input ready);
	modport sink (input valid, action, set_index, way_index, hit, access_kind,
		recency_packed, output ready);
endinterface

interface cwft_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_way;
	logic [15:0] use_distance;
	logic [2:0]  last_kind;
	logic [2:0]  recency_rank;
	logic [15:0] hit_count;
	logic        last;

	modport source (output valid, out_way, use_distance, last_kind, recency_rank,
		hit_count, last, input ready);
	modport sink (input valid, out_way, use_distance, last_kind, recency_rank,
		hit_count, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/cwft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cwft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/cwft_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on cwft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cwft_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire cwft_pkg::cmd_t push_data,
	output logic              full,
	input  wire logic         pop,
	output cwft_pkg::cmd_t    pop_data,
	output logic              empty
);
	cwft_pkg::cmd_t ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && cnt_q == 2'd1) |=> full)
		else $error("queue count lost a push");
endmodule
`default_nettype wire

// ===== rtl/cwft_front.sv =====
// Front end: accepts requests, drops malformed ones, cleans the
// access kind and pushes the command into the queue. Depends on cwft_pkg, cwft_if.
`timescale 1ns / 1ps
`default_nettype none
module cwft_front #(
	parameter int SET_COUNT = 64,
	parameter int WAY_COUNT = 8
) (
	cwft_req_if.sink       req,
	input  wire logic      q_full,
	input  wire logic      clearing,
	output logic           push,
	output cwft_pkg::cmd_t push_data
);
	logic set_ok;
	logic way_ok;
	logic cmd_ok;

	always_comb begin
		set_ok = 32'(req.set_index) < SET_COUNT;
		way_ok = 32'(req.way_index) < WAY_COUNT;
		case (req.action)
			cwft_pkg::ACT_UPDATE: cmd_ok = set_ok && way_ok;
			cwft_pkg::ACT_FILL:   cmd_ok = set_ok && way_ok;
			cwft_pkg::ACT_READ:   cmd_ok = set_ok;
			default:              cmd_ok = 1'b0;
		endcase

		push_data.action         = req.action;
		push_data.set_index      = req.set_index;
		push_data.way_index      = req.way_index;
		push_data.hit            = req.hit;
		push_data.kind           = (req.access_kind <= cwft_pkg::KIND_MAX) ?
			req.access_kind : cwft_pkg::KIND_NONE;
		push_data.recency_packed = req.recency_packed;
	end

	assign req.ready = !q_full && !clearing;
	// requests with an out-of-range set or way or an unknown action are taken and dropped here
	assign push      = req.valid && req.ready && cmd_ok;
endmodule
`default_nettype wire

// ===== rtl/cwft_back.sv =====
// Back end: clears the feature RAM after reset, then runs each command as a
// row read-modify-write or streams one result per way, 8 at most. Depends on cwft_pkg, cwft_if.
`timescale 1ns / 1ps
`default_nettype none
module cwft_back #(
	parameter int SET_COUNT    = 64,
	parameter int WAY_COUNT    = 8,
	parameter int COUNTER_BITS = 16,
	localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1,
	localparam int WAY_W = $clog2(WAY_COUNT),
	localparam int ENT_W = 2 * COUNTER_BITS + 6,
	localparam int ROW_W = WAY_COUNT * ENT_W
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire cwft_pkg::cmd_t q_data,
	output logic                pop,
	output logic                clearing,
	output logic                ram_we,
	output logic [SET_W-1:0]    ram_waddr,
	output logic [ROW_W-1:0]    ram_wdata,
	output logic                ram_re,
	output logic [SET_W-1:0]    ram_raddr,
	input  wire logic [ROW_W-1:0] ram_rdata,
	cwft_res_if.source          res
);
	localparam int CB    = COUNTER_BITS;
	localparam int N_OUT = (WAY_COUNT < cwft_pkg::RESULTS_MAX) ?
		WAY_COUNT : cwft_pkg::RESULTS_MAX;
	localparam int HIT_O  = CB;
	localparam int KIND_O = 2 * CB;
	localparam int RANK_O = 2 * CB + 3;

	cwft_pkg::back_state_t st_q, st_nxt;
	cwft_pkg::cmd_t        cmd_q;
	logic [SET_W-1:0]      clr_q;
	logic [WAY_W-1:0]      w_q;
	logic [ROW_W-1:0]      row_q;
	logic [ROW_W-1:0]      new_row;
	logic [ROW_W-1:0]      reset_row;
	logic [ENT_W-1:0]      emit_ent;
	logic                  load;
	logic                  emit_last;
	logic                  ov_q;

	// row after an update or fill of the command in cmd_q
	always_comb begin
		logic [CB-1:0]          d;
		logic [CB-1:0]          h;
		logic [2:0]             k;
		logic [2:0]             r;
		logic [WAY_W-1:0]       cw;
		cw        = WAY_W'(cmd_q.way_index);
		new_row   = ram_rdata;
		reset_row = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			reset_row[w*ENT_W + KIND_O +: 3] = cwft_pkg::KIND_NONE;
			d = ram_rdata[w*ENT_W +: CB];
			h = ram_rdata[w*ENT_W + HIT_O +: CB];
			k = ram_rdata[w*ENT_W + KIND_O +: 3];
			r = ram_rdata[w*ENT_W + RANK_O +: 3];
			if (cmd_q.action == cwft_pkg::ACT_UPDATE) begin
				d = (&d) ? d : d + CB'(1);
				r = (w < 8) ? cmd_q.recency_packed[3*(w%8) +: 3] : 3'd0;
				if (WAY_W'(w) == cw) begin
					k = cmd_q.kind;
					if (cmd_q.hit) begin
						h = (&h) ? h : h + CB'(1);
						d = '0;
					end
				end
			end else if (WAY_W'(w) == cw) begin
				d = '0;
				h = '0;
				k = cmd_q.kind;
				r = '0;
			end
			new_row[w*ENT_W +: ENT_W] = {r, k, h, d};
		end
	end

	assign emit_ent  = row_q[w_q*ENT_W +: ENT_W];
	assign emit_last = (w_q == WAY_W'(N_OUT - 1));
	assign clearing  = (st_q == cwft_pkg::B_CLEAR);
	assign ram_raddr = SET_W'(q_data.set_index);

	always_comb begin
		st_nxt    = st_q;
		pop       = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = SET_W'(cmd_q.set_index);
		ram_wdata = new_row;
		load      = 1'b0;
		case (st_q)
			cwft_pkg::B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = reset_row;
				if (clr_q == SET_W'(SET_COUNT - 1)) begin
					st_nxt = cwft_pkg::B_IDLE;
				end
			end
			cwft_pkg::B_IDLE: begin
				if (!q_empty) begin
					pop    = 1'b1;
					ram_re = 1'b1;
					st_nxt = cwft_pkg::B_WAIT;
				end
			end
			cwft_pkg::B_WAIT: begin
				if (cmd_q.action == cwft_pkg::ACT_READ) begin
					st_nxt = cwft_pkg::B_EMIT;
				end else begin
					ram_we = 1'b1;
					st_nxt = cwft_pkg::B_IDLE;
				end
			end
			cwft_pkg::B_EMIT: begin
				if (!ov_q || res.ready) begin
					load = 1'b1;
					if (emit_last) begin
						st_nxt = cwft_pkg::B_IDLE;
					end
				end
			end
			default: st_nxt = cwft_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= cwft_pkg::B_CLEAR;
			clr_q <= '0;
			w_q   <= '0;
			ov_q  <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (st_q == cwft_pkg::B_CLEAR) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (st_q == cwft_pkg::B_WAIT) begin
				w_q <= '0;
			end else if (load) begin
				w_q <= w_q + WAY_W'(1);
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_data;
		end
		if (st_q == cwft_pkg::B_WAIT) begin
			row_q <= ram_rdata;
		end
		if (load) begin
			res.out_way      <= 3'(w_q);
			res.use_distance <= cwft_pkg::OUT_CNT_W'(emit_ent[CB-1:0]);
			res.hit_count    <= cwft_pkg::OUT_CNT_W'(emit_ent[HIT_O +: CB]);
			res.last_kind    <= emit_ent[KIND_O +: 3];
			res.recency_rank <= emit_ent[RANK_O +: 3];
			res.last         <= emit_last;
		end
	end

	assign res.valid = ov_q;

	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !ov_q && !pop)
		else $error("activity during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n) !(ram_we && ram_re))
		else $error("RAM read and write in one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == cwft_pkg::B_WAIT && cmd_q.action == cwft_pkg::ACT_READ)
		|=> st_q == cwft_pkg::B_EMIT && w_q == '0)
		else $error("read did not start streaming at way 0");
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && emit_last) |=> st_q == cwft_pkg::B_IDLE && ov_q && res.last)
		else $error("final result not marked or stream did not end");
endmodule
`default_nettype wire

// ===== rtl/cache_way_feature_tracker_top.sv =====
// Cache way feature tracker, top level: front end, command queue, back end
// and feature RAM. Depends on cwft_pkg, cwft_if and the cwft_* modules.
//
// Keeps use distance, hit count, last access kind and recency rank for every
// way of every set, one RAM row per set. After reset the block clears the RAM
// with req.ready low. An update or fill then occupies the back end for a row
// read, then write-back of the modified row; a read occupies it for a row read
// and then min(WAY_COUNT, 8) results, one result per cycle while res.ready is
// high. The back end's occupancy is set by the single read-modify-write path
// through the row RAM and the one-result output register. A two-entry queue lets
// requests be taken while the back end works; requests with an out-of-range set
// or way or an unknown action are taken and dropped.
`timescale 1ns / 1ps
`default_nettype none
module cache_way_feature_tracker_top #(
	parameter int SET_COUNT    = 64,
	parameter int WAY_COUNT    = 8,
	parameter int COUNTER_BITS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cwft_req_if.sink    req,
	cwft_res_if.source  res
);
	localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int ROW_W = WAY_COUNT * (2 * COUNTER_BITS + 6);

	cwft_pkg::cmd_t   push_data;
	cwft_pkg::cmd_t   pop_data;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	logic             clearing;
	logic             ram_we;
	logic             ram_re;
	logic [SET_W-1:0] ram_waddr;
	logic [SET_W-1:0] ram_raddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;

	cwft_front #(
		.SET_COUNT(SET_COUNT),
		.WAY_COUNT(WAY_COUNT)
	) u_front (
		.req      (req),
		.q_full   (q_full),
		.clearing (clearing),
		.push     (push),
		.push_data(push_data)
	);

	cwft_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty)
	);

	cwft_back #(
		.SET_COUNT   (SET_COUNT),
		.WAY_COUNT   (WAY_COUNT),
		.COUNTER_BITS(COUNTER_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.clearing (clearing),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.res      (res)
	);

	cwft_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SET_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);
endmodule
`default_nettype wire
